// ----- design/fgna_pkg.sv -----
// Package for the FIFO gang node allocator.
// Sizes, action and state codes, handshake structs and count saturation.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fgna_pkg;

  localparam int NODE_COUNT  = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int TICK_BITS   = 16;

  localparam int NW  = $clog2(NODE_COUNT + 1);
  localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DREAD,
    ST_DCHECK,
    ST_DALLOC,
    ST_TICK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [NW-1:0]        need;
    logic [TICK_BITS-1:0] ticks;
  } fifo_entry_t;

  typedef struct packed {
    logic accept;
    logic do_add;
    logic start_task;
    logic alloc_step;
    logic tick_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic task_fits;
    logic alloc_last;
    logic tick_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [4:0] sat5(input logic [31:0] v);
    return (v > 32'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

// ----- design/fgna_ctrl.sv -----
// Controller state machine of the FIFO gang node allocator.
// Sequences add, dispatch and tick work; uses fgna_pkg.
`timescale 1ns / 1ps

module fgna_ctrl
  import fgna_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t  state_r, state_nxt;
  action_t action;

  assign action   = action_t'(in_action);
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_ADD:      state_nxt = ST_ADD;
            ACT_DISPATCH: state_nxt = ST_DREAD;
            ACT_TICK:     state_nxt = ST_TICK;
            default:      state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_ADD:   state_nxt = ST_RESULT;
      ST_DREAD: state_nxt = ST_DCHECK;
      ST_DCHECK: begin
        if (!status.q_empty && status.task_fits) begin
          state_nxt = ST_DALLOC;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_DALLOC: begin
        if (status.alloc_last) begin
          state_nxt = ST_DREAD;
        end
      end
      ST_TICK: begin
        if (status.tick_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.accept     = in_valid;
      ST_ADD:    cmd.do_add     = 1'b1;
      ST_DCHECK: cmd.start_task = !status.q_empty && status.task_fits;
      ST_DALLOC: cmd.alloc_step = 1'b1;
      ST_TICK:   cmd.tick_step  = 1'b1;
      ST_RESULT: cmd.load_out   = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- design/fgna_dp.sv -----
// Datapath of the FIFO gang node allocator: task queue memory, node pool,
// countdown memory, counters and result register. Uses fgna_pkg.
`timescale 1ns / 1ps

module fgna_dp
  import fgna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [4:0]  in_task_nodes,
  input  logic [15:0] in_task_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dropped,
  output logic [4:0]  out_started_now,
  output logic [4:0]  out_busy_nodes,
  output logic [4:0]  out_queued_tasks,
  output logic [4:0]  out_running_tasks,
  output logic [31:0] out_finished_total,
  output logic [31:0] out_unfinished_total
);

  fifo_entry_t          fifo_mem [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] rem_mem  [NODE_COUNT];

  fifo_entry_t          head_rd_r;
  logic [TICK_BITS-1:0] rem_rd_r;

  logic [4:0]           nodes_in_r, nodes_in_nxt;
  logic [15:0]          ticks_in_r, ticks_in_nxt;

  logic [NODE_COUNT-1:0] busy_r, busy_nxt;
  logic [NODE_COUNT-1:0] leader_r, leader_nxt;
  logic [NW-1:0]         busy_cnt_r, busy_cnt_nxt;
  logic [NW-1:0]         running_r, running_nxt;
  logic [NW-1:0]         started_r, started_nxt;
  logic [NW-1:0]         need_left_r, need_left_nxt;
  logic [TICK_BITS-1:0]  task_ticks_r, task_ticks_nxt;
  logic                  first_r, first_nxt;
  logic [NIW-1:0]        idx_r, idx_nxt, idx_inc;
  logic [QW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [31:0]           accepted_r, accepted_nxt;
  logic [31:0]           completed_r, completed_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  fifo_we;
  fifo_entry_t           fifo_wdata;
  logic [QW-1:0]         tail;
  logic [QW:0]           tail_sum;
  logic                  rem_we;
  logic [TICK_BITS-1:0]  rem_wdata;
  logic [NW-1:0]         free_cnt;
  logic [NW-1:0]         need_sat;
  logic [TICK_BITS-1:0]  ticks_sat;
  logic                  out_free;

  logic        res_dropped_r;
  logic [4:0]  res_started_r, res_busy_r, res_queued_r, res_running_r;
  logic [31:0] res_finished_r, res_unfinished_r;

  assign out_free = !out_valid_r || !out_stall;
  assign free_cnt = NW'(NODE_COUNT) - busy_cnt_r;

  assign tail_sum = (QW + 1)'(head_r) + (QW + 1)'(count_r);
  assign tail     = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                    QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);

  assign idx_inc = (idx_r == NIW'(NODE_COUNT - 1)) ? '0 : idx_r + 1'b1;

  always_comb begin
    if (32'(nodes_in_r) > 32'(NODE_COUNT)) begin
      need_sat = NW'(NODE_COUNT);
    end else if (nodes_in_r == 5'd0) begin
      need_sat = NW'(1);
    end else begin
      need_sat = NW'(nodes_in_r);
    end
    ticks_sat = TICK_BITS'(ticks_in_r);
    if (ticks_sat == '0) begin
      ticks_sat = TICK_BITS'(1);
    end
  end

  always_comb begin
    status.q_empty    = (count_r == '0);
    status.task_fits  = (head_rd_r.need <= free_cnt);
    status.alloc_last = !busy_r[idx_r] && (need_left_r == NW'(1));
    status.tick_last  = (idx_r == NIW'(NODE_COUNT - 1));
    status.out_free   = out_free;
  end

  always_comb begin
    nodes_in_nxt   = nodes_in_r;
    ticks_in_nxt   = ticks_in_r;
    busy_nxt       = busy_r;
    leader_nxt     = leader_r;
    busy_cnt_nxt   = busy_cnt_r;
    running_nxt    = running_r;
    started_nxt    = started_r;
    need_left_nxt  = need_left_r;
    task_ticks_nxt = task_ticks_r;
    first_nxt      = first_r;
    idx_nxt        = idx_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    accepted_nxt   = accepted_r;
    completed_nxt  = completed_r;
    dropped_nxt    = dropped_r;
    fifo_we        = 1'b0;
    fifo_wdata     = '{need: need_sat, ticks: ticks_sat};
    rem_we         = 1'b0;
    rem_wdata      = task_ticks_r;

    if (cmd.accept) begin
      nodes_in_nxt = in_task_nodes;
      ticks_in_nxt = in_task_ticks;
      dropped_nxt  = 1'b0;
      started_nxt  = '0;
      idx_nxt      = '0;
    end

    if (cmd.do_add) begin
      if (count_r == CW'(QUEUE_DEPTH)) begin
        dropped_nxt = 1'b1;
      end else begin
        fifo_we      = 1'b1;
        count_nxt    = count_r + 1'b1;
        accepted_nxt = accepted_r + 32'd1;
      end
    end

    if (cmd.start_task) begin
      need_left_nxt  = head_rd_r.need;
      task_ticks_nxt = head_rd_r.ticks;
      first_nxt      = 1'b1;
      idx_nxt        = '0;
    end

    if (cmd.alloc_step) begin
      idx_nxt = idx_inc;
      if (!busy_r[idx_r]) begin
        busy_nxt[idx_r]   = 1'b1;
        leader_nxt[idx_r] = first_r;
        rem_we            = 1'b1;
        busy_cnt_nxt      = busy_cnt_r + 1'b1;
        need_left_nxt     = need_left_r - 1'b1;
        first_nxt         = 1'b0;
        if (need_left_r == NW'(1)) begin
          head_nxt    = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt   = count_r - 1'b1;
          running_nxt = running_r + 1'b1;
          started_nxt = started_r + 1'b1;
        end
      end
    end

    if (cmd.tick_step) begin
      idx_nxt = idx_inc;
      if (busy_r[idx_r]) begin
        rem_we    = 1'b1;
        rem_wdata = rem_rd_r - 1'b1;
        if (rem_rd_r == TICK_BITS'(1)) begin
          busy_nxt[idx_r] = 1'b0;
          busy_cnt_nxt    = busy_cnt_r - 1'b1;
          if (leader_r[idx_r]) begin
            leader_nxt[idx_r] = 1'b0;
            completed_nxt     = completed_r + 32'd1;
            if (running_r != '0) begin
              running_nxt = running_r - 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail] <= fifo_wdata;
    end
    head_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[idx_r] <= rem_wdata;
    end
    rem_rd_r <= rem_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      leader_r    <= '0;
      busy_cnt_r  <= '0;
      running_r   <= '0;
      started_r   <= '0;
      first_r     <= 1'b0;
      idx_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      accepted_r  <= '0;
      completed_r <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      leader_r    <= leader_nxt;
      busy_cnt_r  <= busy_cnt_nxt;
      running_r   <= running_nxt;
      started_r   <= started_nxt;
      first_r     <= first_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      accepted_r  <= accepted_nxt;
      completed_r <= completed_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nodes_in_r   <= nodes_in_nxt;
    ticks_in_r   <= ticks_in_nxt;
    need_left_r  <= need_left_nxt;
    task_ticks_r <= task_ticks_nxt;
    if (cmd.load_out) begin
      res_dropped_r    <= dropped_r;
      res_started_r    <= sat5(32'(started_r));
      res_busy_r       <= sat5(32'(busy_cnt_r));
      res_queued_r     <= sat5(32'(count_r));
      res_running_r    <= sat5(32'(running_r));
      res_finished_r   <= completed_r;
      res_unfinished_r <= accepted_r - completed_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_dropped          = res_dropped_r;
  assign out_started_now      = res_started_r;
  assign out_busy_nodes       = res_busy_r;
  assign out_queued_tasks     = res_queued_r;
  assign out_running_tasks    = res_running_r;
  assign out_finished_total   = res_finished_r;
  assign out_unfinished_total = res_unfinished_r;

endmodule

// ----- design/fifo_gang_node_allocator.sv -----
// Channel   Direction  Beat contents
// in_       input      action, task_nodes, task_ticks
// out_      output     dropped, started_now, busy/queued/running counts, totals
//
// One item at a time. Tick walks the nodes one per cycle through the countdown
// memory. Dispatch starts tasks from the queue head while the head task fits,
// scanning at most NODE_COUNT nodes to place each started task.
// Reset is synchronous and needs no clearing pass. A stalled result waits in
// the output register while the next item is already taken in.
// Top level; uses fgna_pkg, fgna_ctrl and fgna_dp.
`timescale 1ns / 1ps

module fifo_gang_node_allocator
  import fgna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_task_nodes,
  input  logic [15:0] in_task_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dropped,
  output logic [4:0]  out_started_now,
  output logic [4:0]  out_busy_nodes,
  output logic [4:0]  out_queued_tasks,
  output logic [4:0]  out_running_tasks,
  output logic [31:0] out_finished_total,
  output logic [31:0] out_unfinished_total
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fgna_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fgna_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_task_nodes        (in_task_nodes),
    .in_task_ticks        (in_task_ticks),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_dropped          (out_dropped),
    .out_started_now      (out_started_now),
    .out_busy_nodes       (out_busy_nodes),
    .out_queued_tasks     (out_queued_tasks),
    .out_running_tasks    (out_running_tasks),
    .out_finished_total   (out_finished_total),
    .out_unfinished_total (out_unfinished_total)
  );

endmodule
